// File: rtl/core/dsd_pkg.sv
package dsd_pkg;

	localparam int NST = 39;

	localparam int LSQ_FIRST = 3;
	localparam int LSQ_LAST  = 10;
	localparam int LSQ_STEPS = 32;
	localparam int RDV_STEPS = 17;
	localparam int UDV_FIRST = 12;
	localparam int UDV_LAST  = 20;
	localparam int UDV_STEPS = 17;
	localparam int QDV_FIRST = 13;
	localparam int QDV_LAST  = 20;
	localparam int QDV_STEPS = 16;
	localparam int SIN_FIRST = 26;
	localparam int SIN_LAST  = 30;
	localparam int SIN_STEPS = 17;
	localparam int SRT_FIRST = 31;
	localparam int SRT_LAST  = 37;
	localparam int SRT_STEPS = 26;

	typedef struct packed {
		logic [2:0][31:0] d;
		logic [2:0][17:0] n;
		logic [14:0]      ior;
		logic             ff;
		logic [15:0]      smp;
	} item_t;

	typedef struct packed {
		logic [2:0][17:0] o;
		logic             refl;
	} res_t;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0]       neg;
		logic [2:0][17:0] n;
		logic [14:0]      iorc;
		logic             ff;
		logic [15:0]      smp;
		logic [2:0][63:0] sq;
		logic [63:0]      lsq;
		logic [33:0]      lrem;
		logic [31:0]      lroot;
		logic [14:0]      rrem;
		logic [16:0]      rq;
		logic [19:0]      r;
		logic [2:0][48:0] num;
		logic [2:0][31:0] urem;
		logic [2:0][16:0] uq;
		logic [19:0]      den;
		logic [19:0]      qrem;
		logic [15:0]      qq;
		logic [15:0]      r0;
		logic [2:0][17:0] u;
		logic [2:0][35:0] un;
		logic [21:0]      dot;
		logic [17:0]      cosv;
		logic [32:0]      cos2;
		logic [17:0]      x;
		logic [2:0][35:0] nc;
		logic [2:0][40:0] rp;
		logic [2:0][26:0] orf;
		logic [2:0][20:0] t;
		logic [21:0]      p;
		logic [32:0]      sarg;
		logic [18:0]      srem;
		logic [16:0]      sroot;
		logic [2:0][41:0] th;
		logic [2:0][25:0] h;
		logic [2:0][50:0] hh;
		logic [51:0]      hs;
		logic [51:0]      sarg2;
		logic [27:0]      s2rem;
		logic [25:0]      s2root;
		logic [36:0]      spr;
		logic [38:0]      pw;
		logic             sref;
		logic             refl;
		logic [2:0][44:0] ns;
		logic [2:0][17:0] o;
	} pipe_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqs_t;

	typedef struct packed {
		logic [31:0] rem;
		logic        q;
	} dvs_t;

	function automatic sqs_t sqrt_step(input sqs_t cur, input logic [1:0] pair);
		logic [35:0] rs;
		logic [35:0] tr;
		sqs_t res;
		rs = {cur.rem, pair};
		tr = {2'b00, cur.root, 2'b01};
		if (rs >= tr) begin
			res.rem  = 34'(rs - tr);
			res.root = {cur.root[30:0], 1'b1};
		end else begin
			res.rem  = rs[33:0];
			res.root = {cur.root[30:0], 1'b0};
		end
		return res;
	endfunction

	function automatic dvs_t div_step(input logic [31:0] rem, input logic [31:0] dv,
		input logic nb);
		logic [32:0] rs;
		dvs_t res;
		rs = {rem, nb};
		if (rs >= {1'b0, dv}) begin
			res.rem = 32'(rs - {1'b0, dv});
			res.q   = 1'b1;
		end else begin
			res.rem = rs[31:0];
			res.q   = 1'b0;
		end
		return res;
	endfunction

	// divide by 2^16, nearest, halves away from zero
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + 64'd32768) >> 16;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [17:0] sat18(input logic signed [63:0] v);
		logic signed [63:0] s;
		s = v;
		if (s > 64'sd65536) s = 64'sd65536;
		if (s < -64'sd65536) s = -64'sd65536;
		return s[17:0];
	endfunction

endpackage

// File: rtl/core/dsd_datapath.sv
module dsd_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  dsd_pkg::item_t din,
	output logic           out_vld,
	output dsd_pkg::res_t  dout
);

	dsd_pkg::pipe_t pipe_s [1:dsd_pkg::NST];
	dsd_pkg::pipe_t src    [1:dsd_pkg::NST];
	logic [dsd_pkg::NST:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[dsd_pkg::NST-1:1], in_vld};
		end
	end

	for (genvar k = 1; k <= dsd_pkg::NST; k++) begin : g_stg
		dsd_pkg::pipe_t nx;

		if (k == 1) begin : g_head
			assign src[k] = '0;
		end else begin : g_body
			assign src[k] = pipe_s[k-1];
		end

		always_comb begin
			dsd_pkg::pipe_t c;
			dsd_pkg::sqs_t sv;
			dsd_pkg::dvs_t dv;
			logic signed [63:0] w;
			logic signed [63:0] acc;
			logic [63:0] uw;
			logic [31:0] av;
			logic [33:0] sa;
			int st;
			c   = src[k];
			nx  = c;
			sv  = '0;
			dv  = '0;
			w   = '0;
			acc = '0;
			uw  = '0;
			av  = '0;
			sa  = '0;
			st  = 0;

			// operand capture, squares of the magnitudes
			if (k == 1) begin
				for (int i = 0; i < 3; i++) begin
					av = din.d[i][31] ? 32'(-$signed(din.d[i])) : din.d[i];
					nx.a[i]   = av;
					nx.neg[i] = din.d[i][31];
					nx.sq[i]  = 64'(av) * 64'(av);
				end
				nx.n    = din.n;
				nx.iorc = (din.ior < 15'd4096) ? 15'd4096 : din.ior;
				nx.ff   = din.ff;
				nx.smp  = din.smp;
			end

			if (k == 2) begin
				nx.lsq   = c.sq[0] + c.sq[1] + c.sq[2];
				nx.lrem  = '0;
				nx.lroot = '0;
				nx.rrem  = 15'd2048;
				nx.rq    = '0;
			end

			// length root and 1/ior share these stages
			if (k >= dsd_pkg::LSQ_FIRST && k <= dsd_pkg::LSQ_LAST) begin
				for (int j = 0; j < 4; j++) begin
					st = (k - dsd_pkg::LSQ_FIRST) * 4 + j;
					if (st < dsd_pkg::LSQ_STEPS) begin
						sv.rem  = nx.lrem;
						sv.root = nx.lroot;
						sv = dsd_pkg::sqrt_step(sv, nx.lsq[63-2*st -: 2]);
						nx.lrem  = sv.rem;
						nx.lroot = sv.root;
					end
				end
				for (int j = 0; j < 3; j++) begin
					st = (k - dsd_pkg::LSQ_FIRST) * 3 + j;
					if (st < dsd_pkg::RDV_STEPS) begin
						dv = dsd_pkg::div_step(32'(nx.rrem), 32'(nx.iorc), 1'b0);
						nx.rrem = 15'(dv.rem);
						nx.rq   = {nx.rq[15:0], dv.q};
					end
				end
			end

			if (k == 11) begin
				nx.r = c.ff ? 20'(c.rq) : {1'b0, c.iorc, 4'b0000};
				for (int i = 0; i < 3; i++) begin
					nx.num[i]  = {1'b0, c.a[i], 16'b0} + 49'(c.lroot >> 1);
					nx.urem[i] = nx.num[i][48:17];
					nx.uq[i]   = '0;
				end
			end

			if (k == 12) begin
				nx.qrem = (c.r > 20'd65536) ? c.r - 20'd65536 : 20'd65536 - c.r;
				nx.den  = 20'd65536 + c.r;
				nx.qq   = '0;
			end

			if (k >= dsd_pkg::UDV_FIRST && k <= dsd_pkg::UDV_LAST) begin
				for (int j = 0; j < 2; j++) begin
					st = (k - dsd_pkg::UDV_FIRST) * 2 + j;
					if (st < dsd_pkg::UDV_STEPS) begin
						for (int i = 0; i < 3; i++) begin
							dv = dsd_pkg::div_step(nx.urem[i], c.lroot, nx.num[i][16-st]);
							nx.urem[i] = dv.rem;
							nx.uq[i]   = {nx.uq[i][15:0], dv.q};
						end
					end
				end
			end

			// schlick base ratio
			if (k >= dsd_pkg::QDV_FIRST && k <= dsd_pkg::QDV_LAST) begin
				for (int j = 0; j < 2; j++) begin
					st = (k - dsd_pkg::QDV_FIRST) * 2 + j;
					if (st < dsd_pkg::QDV_STEPS) begin
						dv = dsd_pkg::div_step(32'(nx.qrem), 32'(nx.den), 1'b0);
						nx.qrem = 20'(dv.rem);
						nx.qq   = {nx.qq[14:0], dv.q};
					end
				end
			end

			if (k == 21) begin
				for (int i = 0; i < 3; i++) begin
					if (c.lroot == '0) begin
						nx.u[i] = '0;
					end else if (c.neg[i]) begin
						nx.u[i] = 18'(-$signed({1'b0, c.uq[i]}));
					end else begin
						nx.u[i] = 18'(c.uq[i]);
					end
				end
				uw = (64'(c.qq) * 64'(c.qq)) >> 16;
				nx.r0 = uw[15:0];
			end

			if (k == 22) begin
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.u[i]) * $signed(c.n[i]);
					nx.un[i] = w[35:0];
				end
			end

			if (k == 23) begin
				acc = $signed(c.un[0]) + $signed(c.un[1]) + $signed(c.un[2]);
				w = dsd_pkg::rnd16(acc);
				nx.dot = w[21:0];
				acc = -w;
				if (acc > 64'sd65536) acc = 64'sd65536;
				if (acc < -64'sd65536) acc = -64'sd65536;
				nx.cosv = acc[17:0];
			end

			if (k == 24) begin
				w = $signed(c.cosv) * $signed(c.cosv);
				nx.cos2 = w[32:0];
				w = 64'sd65536 - $signed(c.cosv);
				nx.x = w[17:0];
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.n[i]) * $signed(c.cosv);
					nx.nc[i] = w[35:0];
					w = 64'sd2 * $signed(c.dot) * $signed(c.n[i]);
					nx.rp[i] = w[40:0];
				end
			end

			if (k == 25) begin
				uw = 64'h1_0000_0000 - 64'(c.cos2);
				nx.sarg  = uw[32:0];
				nx.srem  = '0;
				nx.sroot = '0;
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.u[i]) - dsd_pkg::rnd16($signed(c.rp[i]));
					nx.orf[i] = w[26:0];
					w = $signed(c.u[i]) + dsd_pkg::rnd16($signed(c.nc[i]));
					nx.t[i] = w[20:0];
				end
				uw = (64'(c.x) * 64'(c.x)) >> 16;
				nx.p = uw[21:0];
			end

			// sine root
			if (k >= dsd_pkg::SIN_FIRST && k <= dsd_pkg::SIN_LAST) begin
				sa = {1'b0, c.sarg};
				for (int j = 0; j < 4; j++) begin
					st = (k - dsd_pkg::SIN_FIRST) * 4 + j;
					if (st < dsd_pkg::SIN_STEPS) begin
						sv.rem  = 34'(nx.srem);
						sv.root = 32'(nx.sroot);
						sv = dsd_pkg::sqrt_step(sv, sa[33-2*st -: 2]);
						nx.srem  = 19'(sv.rem);
						nx.sroot = 17'(sv.root);
					end
				end
			end

			if (k >= 26 && k <= 28) begin
				uw = (64'(c.p) * 64'(c.x)) >> 16;
				nx.p = uw[21:0];
			end

			if (k == 26) begin
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.t[i]) * $signed({1'b0, c.r});
					nx.th[i] = w[41:0];
				end
			end

			if (k == 27) begin
				for (int i = 0; i < 3; i++) begin
					w = dsd_pkg::rnd16($signed(c.th[i]));
					nx.h[i] = w[25:0];
				end
			end

			if (k == 28) begin
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.h[i]) * $signed(c.h[i]);
					nx.hh[i] = w[50:0];
				end
			end

			if (k == 29) begin
				uw = 64'(c.hh[0]) + 64'(c.hh[1]) + 64'(c.hh[2]);
				nx.hs = uw[51:0];
				uw = (64'd65536 - 64'(c.r0)) * 64'(c.p);
				nx.pw = uw[38:0];
			end

			if (k == 30) begin
				if (c.hs > 52'h1_0000_0000) begin
					nx.sarg2 = c.hs - 52'h1_0000_0000;
				end else begin
					nx.sarg2 = 52'h1_0000_0000 - c.hs;
				end
				nx.s2rem  = '0;
				nx.s2root = '0;
				uw = 64'(c.r0) + 64'(c.pw >> 16);
				nx.sref = uw > 64'(c.smp);
			end

			// refracted length root
			if (k >= dsd_pkg::SRT_FIRST && k <= dsd_pkg::SRT_LAST) begin
				for (int j = 0; j < 4; j++) begin
					st = (k - dsd_pkg::SRT_FIRST) * 4 + j;
					if (st < dsd_pkg::SRT_STEPS) begin
						sv.rem  = 34'(nx.s2rem);
						sv.root = 32'(nx.s2root);
						sv = dsd_pkg::sqrt_step(sv, nx.sarg2[51-2*st -: 2]);
						nx.s2rem  = 28'(sv.rem);
						nx.s2root = 26'(sv.root);
					end
				end
			end

			if (k == 31) begin
				uw = 64'(c.sroot) * 64'(c.r);
				nx.spr = uw[36:0];
			end

			if (k == 32) begin
				nx.refl = (c.spr > 37'h1_0000_0000) | c.sref;
			end

			if (k == 38) begin
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.n[i]) * $signed({1'b0, c.s2root});
					nx.ns[i] = w[44:0];
				end
			end

			if (k == 39) begin
				for (int i = 0; i < 3; i++) begin
					w = $signed(c.h[i]) - dsd_pkg::rnd16($signed(c.ns[i]));
					acc = c.refl ? 64'($signed(c.orf[i])) : w;
					nx.o[i] = dsd_pkg::sat18(acc);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k] <= nx;
			end
		end
	end

	assign out_vld   = vld_s[dsd_pkg::NST];
	assign dout.o    = pipe_s[dsd_pkg::NST].o;
	assign dout.refl = pipe_s[dsd_pkg::NST].refl;

endmodule

// File: rtl/core/dielectric_scatter_direction.sv
// glass scatter direction with schlick fresnel, fixed point
// slave channel: one ray request per beat; s_tdata holds the direction,
// normal, index of refraction and random sample, s_tuser the front-face flag
// master channel: one result per request, in request order; m_tdata holds
// the scattered unit direction, m_tuser the reflect flag
// throughput: one request per cycle unless the receiver stalls, set by a
// 39-stage pipeline whose length comes from the three square roots and
// three dividers, each done a few bits per stage
// no state is kept between requests
// reset clears all valid bits; the pipeline starts empty
// when the receiver stalls with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated
module dielectric_scatter_direction (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
	// index_of_refraction, random_sample
	input  logic [183:0] s_tdata,
	// front_face
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [55:0]  m_tdata,
	// was_reflected
	output logic [0:0]   m_tuser
);

	dsd_pkg::item_t din;
	dsd_pkg::res_t  dout;
	logic           en;
	logic           out_vld;

	assign en       = !out_vld || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld;

	assign din.d[0] = s_tdata[31:0];
	assign din.d[1] = s_tdata[63:32];
	assign din.d[2] = s_tdata[95:64];
	assign din.n[0] = s_tdata[113:96];
	assign din.n[1] = s_tdata[131:114];
	assign din.n[2] = s_tdata[149:132];
	assign din.ior  = s_tdata[164:150];
	assign din.smp  = s_tdata[180:165];
	assign din.ff   = s_tuser[0];

	dsd_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.din     (din),
		.out_vld (out_vld),
		.dout    (dout)
	);

	assign m_tdata = {2'b00, dout.o[2], dout.o[1], dout.o[0]};
	assign m_tuser = dout.refl;

endmodule

// File: sim/dielectric_scatter_direction_tb.sv
module dielectric_scatter_direction_tb;

	typedef struct {
		logic signed [31:0] d [3];
		logic signed [17:0] n [3];
		logic [14:0]        ior;
		logic               ff;
		logic [15:0]        smp;
	} ray_t;

	typedef struct {
		logic [17:0] o [3];
		logic        refl;
	} scatter_t;

	localparam int LATENCY = 39;
	localparam int STALL_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [183:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic [0:0]   m_tuser;

	ray_t     pending_rays [$];
	scatter_t expected_scatter [$];
	int       mismatches = 0;
	int       idle_cycles;
	int       hold_cycles;
	int       send_gap;
	int       recv_gap;
	bit       hold_active;
	bit       hold_done;

	dielectric_scatter_direction dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_q16(input longint v);
		longint unsigned m;
		if (v < 0) begin
			m = (longint'(-v) + 32768) >> 16;
			return -longint'(m);
		end
		m = (v + 32768) >> 16;
		return longint'(m);
	endfunction

	function automatic logic [17:0] clamp_unit(input longint v);
		if (v > 65536) v = 65536;
		if (v < -65536) v = -65536;
		return v[17:0];
	endfunction

	function automatic scatter_t scatter_ray(input ray_t ray);
		scatter_t res;
		longint d [3];
		longint n [3];
		longint u [3];
		longint o [3];
		longint h [3];
		longint unsigned a;
		longint unsigned lensq;
		longint unsigned len;
		longint unsigned ior;
		longint unsigned ratio;
		longint unsigned sinv;
		longint unsigned x;
		longint unsigned p;
		longint unsigned q;
		longint unsigned r0;
		longint unsigned fres;
		longint unsigned diff;
		longint unsigned hs;
		longint unsigned s;
		longint dot;
		longint cosv;
		logic refl;
		lensq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = ray.d[i];
			n[i] = ray.n[i];
			a = d[i] < 0 ? -d[i] : d[i];
			lensq += a * a;
		end
		len = int_sqrt(lensq);
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				u[i] = 0;
			end else begin
				a = d[i] < 0 ? -d[i] : d[i];
				u[i] = longint'((a * 65536 + len / 2) / len);
				if (d[i] < 0) u[i] = -u[i];
			end
		end
		ior = ray.ior < 4096 ? 4096 : ray.ior;
		ratio = ray.ff ? (64'd1 << 28) / ior : ior * 16;
		dot = 0;
		for (int i = 0; i < 3; i++) dot += u[i] * n[i];
		dot = round_q16(dot);
		cosv = -dot;
		if (cosv > 65536) cosv = 65536;
		if (cosv < -65536) cosv = -65536;
		sinv = int_sqrt((64'd1 << 32) - longint'(cosv * cosv));
		refl = sinv * ratio > (64'd1 << 32);
		if (!refl) begin
			diff = ratio > 65536 ? ratio - 65536 : 65536 - ratio;
			q = (diff << 16) / (65536 + ratio);
			r0 = (q * q) >> 16;
			x = 65536 - cosv;
			p = x;
			for (int i = 0; i < 4; i++) p = (p * x) >> 16;
			fres = r0 + (((65536 - r0) * p) >> 16);
			refl = fres > ray.smp;
		end
		if (refl) begin
			for (int i = 0; i < 3; i++) o[i] = u[i] - round_q16(2 * dot * n[i]);
		end else begin
			hs = 0;
			for (int i = 0; i < 3; i++) begin
				h[i] = round_q16((u[i] + round_q16(n[i] * cosv)) * longint'(ratio));
				hs += h[i] * h[i];
			end
			s = int_sqrt(hs > (64'd1 << 32) ? hs - (64'd1 << 32) : (64'd1 << 32) - hs);
			for (int i = 0; i < 3; i++) o[i] = h[i] - round_q16(n[i] * longint'(s));
		end
		for (int i = 0; i < 3; i++) res.o[i] = clamp_unit(o[i]);
		res.refl = refl;
		return res;
	endfunction

	function automatic int gap_length();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [17:0] rand_normal_comp();
		case ($urandom_range(0, 5))
			0: return 18'sd65536;
			1: return -18'sd65536;
			2: return 18'($urandom);
			default: return 18'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	// mostly unit normals opposing the ray, some free noise
	function automatic ray_t rand_ray();
		ray_t ray;
		real vx;
		real vy;
		real vz;
		real l;
		int sc;
		sc = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			case (sc)
				0: ray.d[i] = $urandom;
				1: ray.d[i] = $signed($urandom_range(0, 8'hff)) - 128;
				default: ray.d[i] = $signed($urandom_range(0, 32'h3ffff)) - 32'h20000;
			endcase
		end
		if ($urandom_range(0, 9) < 8) begin
			vx = $itor($signed($urandom_range(0, 2000)) - 1000);
			vy = $itor($signed($urandom_range(0, 2000)) - 1000);
			vz = $itor($signed($urandom_range(0, 2000)) - 1000);
			l = $sqrt(vx * vx + vy * vy + vz * vz);
			if (l < 1.0) begin
				vx = 1.0;
				l = 1.0;
			end
			if (vx * ray.d[0] + vy * ray.d[1] + vz * ray.d[2] > 0.0) begin
				vx = -vx;
				vy = -vy;
				vz = -vz;
			end
			ray.n[0] = 18'($rtoi(vx / l * 65536.0));
			ray.n[1] = 18'($rtoi(vy / l * 65536.0));
			ray.n[2] = 18'($rtoi(vz / l * 65536.0));
		end else begin
			for (int i = 0; i < 3; i++) ray.n[i] = rand_normal_comp();
		end
		case ($urandom_range(0, 4))
			0: ray.ior = 15'($urandom);
			1: ray.ior = 15'($urandom_range(0, 4095));
			default: ray.ior = 15'($urandom_range(4096, 7000));
		endcase
		ray.ff = 1'($urandom);
		ray.smp = 16'($urandom);
		return ray;
	endfunction

	function automatic ray_t make_ray(input int dx, input int dy, input int dz,
		input int nx, input int ny, input int nz, input int ior, input bit ff,
		input int smp);
		ray_t ray;
		ray.d[0] = dx;
		ray.d[1] = dy;
		ray.d[2] = dz;
		ray.n[0] = 18'(nx);
		ray.n[1] = 18'(ny);
		ray.n[2] = 18'(nz);
		ray.ior = 15'(ior);
		ray.ff = ff;
		ray.smp = 16'(smp);
		return ray;
	endfunction

	initial begin
		int unsigned big;
		big = 32'h7fffffff;
		pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 65536, 6144, 1, 0));
		pending_rays.push_back(make_ray(0, 0, 0, 0, 0, -65536, 6144, 0, 65535));
		pending_rays.push_back(make_ray(0, 0, -65536, 0, 0, 65536, 6144, 1, 65535));
		pending_rays.push_back(make_ray(0, 0, -65536, 0, 0, 65536, 6144, 0, 0));
		pending_rays.push_back(make_ray(big, big, big, -37837, -37837, -37837, 32767, 1, 65535));
		pending_rays.push_back(make_ray(-big - 1, -big - 1, -big - 1, 37837, 37837, 37837,
			32767, 0, 65535));
		pending_rays.push_back(make_ray(-big - 1, 0, 0, 65536, 0, 0, 0, 1, 65535));
		pending_rays.push_back(make_ray(1, 0, 0, -65536, 0, 0, 4095, 0, 32768));
		pending_rays.push_back(make_ray(65536, 65536, 0, 0, -65536, 0, 4096, 1, 100));
		pending_rays.push_back(make_ray(65536, 65536, 0, 0, -65536, 0, 6144, 0, 65535));
		pending_rays.push_back(make_ray(65536, 3000, 0, 0, -65536, 0, 6144, 1, 65535));
		pending_rays.push_back(make_ray(0, 0, 65536, 0, 0, 65536, 6144, 1, 65535));
		pending_rays.push_back(make_ray(1000, -2000, 3000, 131071, -131072, 131071, 8000, 1,
			20000));
		pending_rays.push_back(make_ray(-5, 7, -9, -131072, 131071, -1, 12000, 0, 1));
		for (int i = 0; i < 1250; i++) pending_rays.push_back(rand_ray());
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		ray_t ray;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_scatter.push_back(scatter_ray(pending_rays.pop_front()));
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0 || pending_rays.size() == 0
						|| (s_tvalid && s_tready && pending_rays.size() == 0)) begin
					s_tvalid <= 1'b0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end else begin
					ray = pending_rays[0];
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, ray.smp, ray.ior, ray.n[2], ray.n[1], ray.n[0],
						ray.d[2], ray.d[1], ray.d[0]};
					s_tuser <= ray.ff;
					send_gap <= gap_length();
				end
			end
		end
	end

	// the driver pops at accept, so it offers pending_rays[0] only after that pop
	// next offer must reflect the queue after the pop: handled by offering head
	// of the queue, which is only read after the accept has popped above

	// long receiver hold once a good part of the stimulus is out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done) begin
			if (hold_active) begin
				hold_cycles <= hold_cycles + 1;
				if (hold_cycles >= 300) begin
					hold_active <= 1'b0;
					hold_done <= 1'b1;
				end
			end else if (pending_rays.size() < 1000) begin
				hold_active <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		scatter_t exp_res;
		logic [17:0] got [3];
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got[0] = m_tdata[17:0];
				got[1] = m_tdata[35:18];
				got[2] = m_tdata[53:36];
				if (expected_scatter.size() == 0) begin
					$display("%0t: unexpected result %h / %b", $time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					exp_res = expected_scatter.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (got[i] !== exp_res.o[i]) begin
							$display("%0t: out[%0d] expected %h actual %h", $time, i,
								exp_res.o[i], got[i]);
							mismatches++;
						end
					end
					if (m_tuser[0] !== exp_res.refl) begin
						$display("%0t: was_reflected expected %b actual %b", $time,
							exp_res.refl, m_tuser[0]);
						mismatches++;
					end
				end
			end
			if (hold_active) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= gap_length();
			end
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
			if (pending_rays.size() == 0 && !s_tvalid && expected_scatter.size() == 0)
				break;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_scatter.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/dsd_pkg.sv
rtl/core/dsd_datapath.sv
rtl/core/dielectric_scatter_direction.sv
sim/dielectric_scatter_direction_tb.sv
